// ===== design/icle_pkg.sv =====
`timescale 1ns / 1ps
package icle_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int FUNC_W   = 4;
   localparam int INDEX_W  = 7;
   localparam int ELEM_W   = 8;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FN_READ       = 4'd0;
   localparam logic [FUNC_W-1:0] FN_REPLACE    = 4'd1;
   localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd3;
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd4;
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd7;
   localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SH_UP_RD,
      S_SH_UP_WR,
      S_WR_ELEM,
      S_SH_DN_RD,
      S_SH_DN_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                latch;
      logic                status_we;
      logic [STATUS_W-1:0] status_code;
      logic                rd_idx;
      logic                rd_up;
      logic                rd_dn;
      logic                wr_elem_idx;
      logic                wr_elem_fill;
      logic                wr_ptr;
      logic                ptr_load_up;
      logic                ptr_load_dn;
      logic                ptr_inc;
      logic                ptr_dec;
      logic                fill_inc;
      logic                fill_dec;
      logic                fill_clr;
      logic                out_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              idx_lt_fill;
      logic              idx_le_fill;
      logic              empty;
      logic              full;
      logic              up_done;
      logic              dn_done;
      logic              out_busy;
   } sts_type;

endpackage

// ===== design/icle_ram.sv =====
`timescale 1ns / 1ps
module icle_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/icle_ctrl.sv =====
`timescale 1ns / 1ps
module icle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  icle_pkg::sts_type sts,
   output icle_pkg::cmd_type cmd
);

   icle_pkg::state_type state_ff;
   icle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         icle_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = icle_pkg::S_EXEC;
            end
         end
         icle_pkg::S_EXEC: begin
            state_in = icle_pkg::S_FINISH;
            case (sts.func)
               icle_pkg::FN_INSERT: begin
                  if (sts.idx_le_fill && !sts.full) begin
                     state_in = icle_pkg::S_SH_UP_RD;
                  end
               end
               icle_pkg::FN_PUSH_FRONT: begin
                  if (!sts.full) begin
                     state_in = icle_pkg::S_SH_UP_RD;
                  end
               end
               icle_pkg::FN_REMOVE: begin
                  if (sts.idx_lt_fill) begin
                     state_in = icle_pkg::S_SH_DN_RD;
                  end
               end
               icle_pkg::FN_POP_FRONT: begin
                  if (!sts.empty) begin
                     state_in = icle_pkg::S_SH_DN_RD;
                  end
               end
               default: begin
                  state_in = icle_pkg::S_FINISH;
               end
            endcase
         end
         icle_pkg::S_SH_UP_RD: begin
            state_in = sts.up_done ? icle_pkg::S_WR_ELEM : icle_pkg::S_SH_UP_WR;
         end
         icle_pkg::S_SH_UP_WR: begin
            state_in = icle_pkg::S_SH_UP_RD;
         end
         icle_pkg::S_WR_ELEM: begin
            state_in = icle_pkg::S_FINISH;
         end
         icle_pkg::S_SH_DN_RD: begin
            state_in = sts.dn_done ? icle_pkg::S_FINISH : icle_pkg::S_SH_DN_WR;
         end
         icle_pkg::S_SH_DN_WR: begin
            state_in = icle_pkg::S_SH_DN_RD;
         end
         icle_pkg::S_FINISH: begin
            if (!sts.out_busy) begin
               state_in = icle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = icle_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         icle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         icle_pkg::S_EXEC: begin
            cmd.status_we   = 1'b1;
            cmd.status_code = icle_pkg::STS_OK;
            case (sts.func)
               icle_pkg::FN_READ: begin
                  if (sts.idx_lt_fill) begin
                     cmd.rd_idx = 1'b1;
                  end else begin
                     cmd.status_code = icle_pkg::STS_RANGE;
                  end
               end
               icle_pkg::FN_REPLACE: begin
                  if (sts.idx_lt_fill) begin
                     cmd.wr_elem_idx = 1'b1;
                  end else begin
                     cmd.status_code = icle_pkg::STS_RANGE;
                  end
               end
               icle_pkg::FN_INSERT: begin
                  if (!sts.idx_le_fill) begin
                     cmd.status_code = icle_pkg::STS_RANGE;
                  end else if (sts.full) begin
                     cmd.status_code = icle_pkg::STS_FULL;
                  end else begin
                     cmd.ptr_load_up = 1'b1;
                  end
               end
               icle_pkg::FN_REMOVE: begin
                  if (sts.idx_lt_fill) begin
                     cmd.ptr_load_dn = 1'b1;
                  end else begin
                     cmd.status_code = icle_pkg::STS_RANGE;
                  end
               end
               icle_pkg::FN_PUSH_FRONT: begin
                  if (sts.full) begin
                     cmd.status_code = icle_pkg::STS_FULL;
                  end else begin
                     cmd.ptr_load_up = 1'b1;
                  end
               end
               icle_pkg::FN_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.status_code = icle_pkg::STS_FULL;
                  end else begin
                     cmd.wr_elem_fill = 1'b1;
                     cmd.fill_inc     = 1'b1;
                  end
               end
               icle_pkg::FN_POP_FRONT: begin
                  if (sts.empty) begin
                     cmd.status_code = icle_pkg::STS_EMPTY;
                  end else begin
                     cmd.ptr_load_dn = 1'b1;
                  end
               end
               icle_pkg::FN_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.status_code = icle_pkg::STS_EMPTY;
                  end else begin
                     cmd.fill_dec = 1'b1;
                  end
               end
               icle_pkg::FN_CLEAR: begin
                  cmd.fill_clr = 1'b1;
               end
               default: begin
                  cmd.status_code = icle_pkg::STS_OK;
               end
            endcase
         end
         icle_pkg::S_SH_UP_RD: begin
            cmd.rd_up = !sts.up_done;
         end
         icle_pkg::S_SH_UP_WR: begin
            cmd.wr_ptr  = 1'b1;
            cmd.ptr_dec = 1'b1;
         end
         icle_pkg::S_WR_ELEM: begin
            cmd.wr_elem_idx = 1'b1;
            cmd.fill_inc    = 1'b1;
         end
         icle_pkg::S_SH_DN_RD: begin
            cmd.rd_dn    = !sts.dn_done;
            cmd.fill_dec = sts.dn_done;
         end
         icle_pkg::S_SH_DN_WR: begin
            cmd.wr_ptr  = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         icle_pkg::S_FINISH: begin
            cmd.out_load = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/icle_dp.sv =====
`timescale 1ns / 1ps
module icle_dp #(
   parameter int CAPACITY = icle_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [icle_pkg::FUNC_W-1:0]   req_func,
   input  logic [icle_pkg::INDEX_W-1:0]  req_index,
   input  logic [icle_pkg::ELEM_W-1:0]   req_elem,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [icle_pkg::ELEM_W-1:0]   rsp_data,
   output logic [icle_pkg::COUNT_W-1:0]  rsp_count,
   output logic [icle_pkg::STATUS_W-1:0] rsp_status,
   input  icle_pkg::cmd_type             cmd,
   output icle_pkg::sts_type             sts
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > icle_pkg::INDEX_W) ? CW : icle_pkg::INDEX_W;

   logic [icle_pkg::FUNC_W-1:0]   func_ff;
   logic [icle_pkg::INDEX_W-1:0]  idx_ff;
   logic [icle_pkg::ELEM_W-1:0]   elem_ff;
   logic                          rd_sel_ff;
   logic [icle_pkg::STATUS_W-1:0] status_ff;
   logic [CW-1:0]                 fill_ff;
   logic [CW-1:0]                 fill_in;
   logic [CW-1:0]                 ptr_ff;
   logic [CW-1:0]                 ptr_in;
   logic                          rsp_valid_ff;
   logic [icle_pkg::ELEM_W-1:0]   rsp_data_ff;
   logic [icle_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [icle_pkg::STATUS_W-1:0] rsp_status_ff;

   logic [CMPW-1:0]             idx_ext;
   logic [CMPW-1:0]             fill_ext;
   logic [CW-1:0]               ptr_m1;
   logic [CW-1:0]               ptr_p1;
   logic [CW:0]                 ptr_p1_wide;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [icle_pkg::ELEM_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [icle_pkg::ELEM_W-1:0] ram_rd_data;
   logic                        front_op;

   assign idx_ext     = CMPW'(idx_ff);
   assign fill_ext    = CMPW'(fill_ff);
   assign ptr_m1      = ptr_ff - 1'b1;
   assign ptr_p1      = ptr_ff + 1'b1;
   assign ptr_p1_wide = {1'b0, ptr_ff} + 1'b1;
   assign front_op    = (req_func == icle_pkg::FN_PUSH_FRONT) ||
                        (req_func == icle_pkg::FN_POP_FRONT);

   // request hold, plus status and shift pointer registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         idx_ff  <= front_op ? '0 : req_index;
         elem_ff <= req_elem;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      ptr_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff    <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.latch) begin
            rd_sel_ff <= 1'b0;
         end else if (cmd.rd_idx) begin
            rd_sel_ff <= 1'b1;
         end
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.out_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clr) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_load_up) begin
         ptr_in = fill_ff;
      end else if (cmd.ptr_load_dn) begin
         ptr_in = idx_ext[CW-1:0];
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_m1;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_p1;
      end
   end

   // memory port steering
   always_comb begin
      ram_wr_en   = cmd.wr_elem_idx || cmd.wr_elem_fill || cmd.wr_ptr;
      ram_wr_addr = ptr_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      if (cmd.wr_elem_idx) begin
         ram_wr_addr = idx_ext[AW-1:0];
         ram_wr_data = elem_ff;
      end else if (cmd.wr_elem_fill) begin
         ram_wr_addr = fill_ff[AW-1:0];
         ram_wr_data = elem_ff;
      end
   end

   always_comb begin
      ram_rd_en   = cmd.rd_idx || cmd.rd_up || cmd.rd_dn;
      ram_rd_addr = idx_ext[AW-1:0];
      if (cmd.rd_up) begin
         ram_rd_addr = ptr_m1[AW-1:0];
      end else if (cmd.rd_dn) begin
         ram_rd_addr = ptr_p1[AW-1:0];
      end
   end

   icle_ram #(
      .WIDTH (icle_pkg::ELEM_W),
      .DEPTH (CAPACITY)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff   <= rd_sel_ff ? ram_rd_data : '0;
         rsp_count_ff  <= fill_ext[icle_pkg::COUNT_W-1:0];
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      sts.func        = func_ff;
      sts.idx_lt_fill = idx_ext < fill_ext;
      sts.idx_le_fill = idx_ext <= fill_ext;
      sts.empty       = fill_ff == '0;
      sts.full        = fill_ff == CW'(CAPACITY);
      sts.up_done     = CMPW'(ptr_ff) == idx_ext;
      sts.dn_done     = ptr_p1_wide >= {1'b0, fill_ff};
      sts.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill above capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while held");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> fill_ff != CW'(CAPACITY))
      else $error("fill raised on a full list");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_dec |-> fill_ff != '0)
      else $error("fill lowered on an empty list");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_ptr |-> ptr_ff < fill_ff || (ptr_ff == fill_ff && fill_ff != CW'(CAPACITY)))
      else $error("shift write outside the list");

endmodule

// ===== design/indexed_char_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Ordered byte list of CAPACITY entries held in a RAM with one read and one
// write port, one item in flight at a time. Read, replace, push back, pop back,
// clear and any refused request pass through the execute and finish states
// only, and the next item is taken once the block is back in idle. Insert, push
// front, remove and pop front move entries one at a time through the RAM, a
// read and then a write for every entry moved. Insert and push front move every
// entry from the index to the end of the list and then write the new entry;
// remove and pop front move the entries above the index and then lower the
// fill. A finished result sits in an output register, so the block returns to
// accepting as soon as that register is free.
module indexed_char_list_engine_unit #(
   parameter int CAPACITY = icle_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [icle_pkg::FUNC_W-1:0]   req_func,
   input  logic [icle_pkg::INDEX_W-1:0]  req_index,
   input  logic [icle_pkg::ELEM_W-1:0]   req_elem,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [icle_pkg::ELEM_W-1:0]   rsp_data,
   output logic [icle_pkg::COUNT_W-1:0]  rsp_count,
   output logic [icle_pkg::STATUS_W-1:0] rsp_status
);

   icle_pkg::cmd_type cmd;
   icle_pkg::sts_type sts;

   icle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   icle_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_func   (req_func),
      .req_index  (req_index),
      .req_elem   (req_elem),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== tb/sv/byte_list_checker.sv =====
`timescale 1ns / 1ps
module byte_list_checker
   import icle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [ELEM_W-1:0]   req_elem,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [ELEM_W-1:0]   rsp_data,
   input  logic [COUNT_W-1:0]  rsp_count,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  failures,
   output int                  pending,
   output int                  list_fill
);

   typedef struct packed {
      logic [ELEM_W-1:0]   data;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } list_outcome_t;

   logic [ELEM_W-1:0] cells [CAPACITY];
   int                fill;
   list_outcome_t     outcome_q [$];

   // move entries from at upwards by one place
   function automatic void open_gap(input int at);
      int k;
      for (k = fill; k > at; k--) cells[k] = cells[k-1];
   endfunction

   // move entries above at downwards by one place
   function automatic void close_gap(input int at);
      int k;
      for (k = at; k < fill - 1; k++) cells[k] = cells[k+1];
   endfunction

   function automatic list_outcome_t list_op_outcome(input logic [FUNC_W-1:0] func,
                                                     input logic [INDEX_W-1:0] index,
                                                     input logic [ELEM_W-1:0] elem);
      list_outcome_t r;
      int            ix;
      r.data   = '0;
      r.status = STS_OK;
      ix       = int'(index);
      case (func)
         FN_READ: begin
            if (ix < fill) r.data = cells[ix];
            else r.status = STS_RANGE;
         end
         FN_REPLACE: begin
            if (ix < fill) cells[ix] = elem;
            else r.status = STS_RANGE;
         end
         FN_INSERT: begin
            if (ix > fill) r.status = STS_RANGE;
            else if (fill >= CAPACITY) r.status = STS_FULL;
            else begin
               open_gap(ix);
               cells[ix] = elem;
               fill++;
            end
         end
         FN_REMOVE: begin
            if (ix < fill) begin
               close_gap(ix);
               fill--;
            end else r.status = STS_RANGE;
         end
         FN_PUSH_FRONT: begin
            if (fill >= CAPACITY) r.status = STS_FULL;
            else begin
               open_gap(0);
               cells[0] = elem;
               fill++;
            end
         end
         FN_PUSH_BACK: begin
            if (fill >= CAPACITY) r.status = STS_FULL;
            else begin
               cells[fill] = elem;
               fill++;
            end
         end
         FN_POP_FRONT: begin
            if (fill == 0) r.status = STS_EMPTY;
            else begin
               close_gap(0);
               fill--;
            end
         end
         FN_POP_BACK: begin
            if (fill == 0) r.status = STS_EMPTY;
            else fill--;
         end
         FN_CLEAR: begin
            fill = 0;
         end
         default: begin
         end
      endcase
      r.count = fill[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_outcome_t want;
      if (reset) begin
         fill = 0;
         outcome_q.delete();
      end else begin
         if (req_valid && req_ready)
            outcome_q.push_back(list_op_outcome(req_func, req_index, req_elem));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected result item: data %0d count %0d status %0d",
                      rsp_data, rsp_count, rsp_status);
               failures++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, rsp_data);
                  failures++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
            end
         end
      end
      pending   = outcome_q.size();
      list_fill = fill;
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import icle_pkg::*;

   localparam int RESET_CYCLES    = 5;
   localparam int STALL_LIMIT     = 5000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 150;
   localparam int PHASE_ITEMS     = 330;
   localparam int INDEX_MAX       = (1 << INDEX_W) - 1;

   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} traffic_mix_t;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func;
   logic [INDEX_W-1:0]  req_index;
   logic [ELEM_W-1:0]   req_elem;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ELEM_W-1:0]   rsp_data;
   logic [COUNT_W-1:0]  rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   int failures;
   int pending;
   int list_fill;
   int snd_idle_pct = 14;
   int rcv_idle_pct = 73;
   int idle_cycles  = 0;
   int hold_req_cnt = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   indexed_char_list_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_index  (req_index),
      .req_elem   (req_elem),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

   byte_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_index  (req_index),
      .req_elem   (req_elem),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .failures   (failures),
      .pending    (pending),
      .list_fill  (list_fill)
   );

   // receiver: random back-pressure, plus one long hold-off when asked
   initial begin
      int hold_seen;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] index,
                            input logic [ELEM_W-1:0] elem);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_index <= index;
      req_elem  <= elem;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random(input traffic_mix_t mix);
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      int                 r;
      r = $urandom_range(99);
      case (mix)
         MIX_GROW: begin
            if (r < 30) func = FN_PUSH_BACK;
            else if (r < 55) func = FN_PUSH_FRONT;
            else if (r < 80) func = FN_INSERT;
            else if (r < 90) func = FN_READ;
            else func = FN_REPLACE;
         end
         MIX_SHRINK: begin
            if (r < 20) func = FN_POP_FRONT;
            else if (r < 40) func = FN_POP_BACK;
            else if (r < 65) func = FN_REMOVE;
            else if (r < 85) func = FN_READ;
            else if (r < 95) func = FN_REPLACE;
            else func = FN_INSERT;
         end
         MIX_BALANCED: begin
            if (r < 2) func = FN_CLEAR;
            else func = FUNC_W'($urandom_range(FN_READ, FN_POP_BACK));
         end
         default: begin
            func = FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1));
         end
      endcase
      r = $urandom_range(99);
      if (mix == MIX_NOISE || r >= 94) index = INDEX_W'($urandom_range(0, INDEX_MAX));
      else if (r < 70) index = INDEX_W'($urandom_range(0, list_fill));
      else if (r < 80) index = INDEX_W'(list_fill);
      else if (r < 88) index = INDEX_W'(list_fill + 1);
      else index = (list_fill > 0) ? INDEX_W'(list_fill - 1) : '0;
      send_item(func, index, ELEM_W'($urandom_range(0, 255)));
   endtask

   // growth-heavy mix so that the list reaches capacity now and then
   task automatic r_pick_mix(output traffic_mix_t mix);
      int r;
      r = $urandom_range(9);
      if (r < 4) mix = MIX_GROW;
      else if (r < 7) mix = MIX_SHRINK;
      else if (r < 9) mix = MIX_BALANCED;
      else mix = MIX_NOISE;
   endtask

   initial begin
      traffic_mix_t mix;
      int           block_left;
      int           n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FN_READ;
      req_index = '0;
      req_elem  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty list: range and empty refusals
      send_item(FN_READ, 7'd0, 8'h00);
      send_item(FN_REMOVE, 7'd0, 8'h00);
      send_item(FN_REPLACE, 7'd0, 8'h11);
      send_item(FN_POP_FRONT, 7'd0, 8'h00);
      send_item(FN_POP_BACK, 7'd0, 8'h00);
      send_item(FN_INSERT, 7'd1, 8'h22);
      // build a short list through every way in
      send_item(FN_INSERT, 7'd0, 8'hFF);
      send_item(FN_PUSH_FRONT, 7'd0, 8'h00);
      send_item(FN_PUSH_BACK, 7'd0, 8'hA5);
      send_item(FN_INSERT, 7'd3, 8'h5A);
      send_item(FN_INSERT, 7'd2, 8'h3C);
      send_item(FN_READ, 7'd0, 8'h00);
      send_item(FN_READ, 7'd2, 8'h00);
      send_item(FN_READ, 7'd4, 8'h00);
      send_item(FN_READ, INDEX_W'(INDEX_MAX), 8'hFF);
      send_item(FN_REPLACE, 7'd1, 8'h81);
      send_item(FN_READ, 7'd1, 8'h00);
      send_item(FN_REMOVE, 7'd4, 8'h00);
      send_item(FN_REMOVE, 7'd0, 8'h00);
      send_item(FN_POP_FRONT, 7'd0, 8'h00);
      send_item(FN_POP_BACK, 7'd0, 8'h00);
      send_item(FN_UNUSED_LO, INDEX_W'(INDEX_MAX), 8'hFF);
      send_item(FN_UNUSED_HI, 7'd0, 8'h00);
      send_item(FN_CLEAR, 7'd0, 8'h00);
      send_item(FN_READ, 7'd0, 8'h00);
      wait_drained();

      for (n = 0; n < 3; n++) begin
         case (n)
            0: begin
               snd_idle_pct = 14;
               rcv_idle_pct = 73;
            end
            1: begin
               snd_idle_pct = 73;
               rcv_idle_pct = 14;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         block_left = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == 100) hold_req_cnt++;
            if (block_left == 0) begin
               r_pick_mix(mix);
               block_left = $urandom_range(20, 120);
            end
            block_left--;
            send_random(mix);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/icle_pkg.sv
design/icle_ram.sv
design/icle_ctrl.sv
design/icle_dp.sv
design/indexed_char_list_engine_unit.sv
tb/sv/byte_list_checker.sv
tb/sv/testbench.sv
